FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by bcsm_ctrl.
// All macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BCSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that expect_next holds in the cycle after cond.
`define BCSM_ASSERT_NEXT(lbl, cond, expect_next) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (expect_next)) else $error("assertion failed");

`endif

FILE: hw/rtl/bcsm_pkg.sv
// ----------------------------------------------------------------------------
// bcsm_pkg
// Shared types and constants of the battery charge-state monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcsm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_LOW_THR     = 3'd0;
  localparam logic [2:0] REG_ALERTS_ON   = 3'd1;
  localparam logic [2:0] REG_LOW_ALERT   = 3'd2;
  localparam logic [2:0] REG_CHG_ALERT   = 3'd3;
  localparam logic [2:0] REG_FULL_ALERT  = 3'd4;
  localparam logic [2:0] REG_FULL_HOLD   = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Levels in 1/256 percent, voltage in 1.25 mV units
  localparam logic [14:0] PCT_FULL_Q8   = 15'd25600;
  localparam logic [14:0] PCT_99_Q8     = 15'd25344;
  localparam logic [14:0] PCT_10_Q8     = 15'd2560;
  localparam logic [14:0] PCT_5_Q8      = 15'd1280;
  localparam logic [6:0]  LOW_THR_DEF   = 7'd15;
  localparam logic [11:0] FULL_VOLT     = 12'd3320;

  // Rate in 1/1280 %/h
  localparam logic signed [24:0] RATE_THRESH = 25'sd256;
  localparam logic signed [39:0] RATE_MAX    = 40'sd16777215;
  localparam logic signed [39:0] RATE_MIN    = -40'sd16777216;
  localparam logic signed [39:0] RATE_SCALE  = 40'sd18000000;
  localparam int unsigned        RATE_DIV_W  = 39;
  // x / 10 equals (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0]        RECIP10     = 32'hCCCC_CCCD;

  // Charge state codes
  localparam logic [1:0] CS_CRITICAL    = 2'd0;
  localparam logic [1:0] CS_FULL        = 2'd1;
  localparam logic [1:0] CS_CHARGING    = 2'd2;
  localparam logic [1:0] CS_DISCHARGING = 2'd3;

  // Charge alert codes
  localparam logic [1:0] CA_NONE    = 2'd0;
  localparam logic [1:0] CA_STARTED = 2'd1;
  localparam logic [1:0] CA_STOPPED = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prime;
    logic mul;
    logic div_start;
    logic mix;
    logic rate;
    logic commit;
  } bcsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_rate;
    logic primed;
    logic div_done;
    logic out_free;
  } bcsm_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bcsm_if.sv
// ----------------------------------------------------------------------------
// bcsm_if
// Sample and status channels of the charge-state monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcsm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] vcell_raw;
  logic [15:0] soc_raw;
  logic [31:0] now_ms;

  modport source (output valid, vcell_raw, soc_raw, now_ms, input ready);
  modport sink   (input valid, vcell_raw, soc_raw, now_ms, output ready);
endinterface

interface bcsm_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        voltage_units;
  logic [14:0]        percent_q8;
  logic signed [24:0] rate_q;
  logic               charging;
  logic               full_res;
  logic               low;
  logic [1:0]         charge_state;
  logic               low_alert;
  logic [1:0]         charge_alert;
  logic               full_alert;
  logic               critical_sleep;

  modport source (output valid, voltage_units, percent_q8, rate_q, charging, full_res,
                  low, charge_state, low_alert, charge_alert, full_alert, critical_sleep,
                  input ready);
  modport sink   (input valid, voltage_units, percent_q8, rate_q, charging, full_res,
                  low, charge_state, low_alert, charge_alert, full_alert, critical_sleep,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bcsm_div.sv
// ----------------------------------------------------------------------------
// bcsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcsm_div #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_d = diff;
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold operands
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = num_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bcsm_datapath.sv
// ----------------------------------------------------------------------------
// bcsm_datapath
// Sample registers, rate arithmetic, flags, configuration and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcsm_datapath
  import bcsm_pkg::*;
#(
  parameter int unsigned TIME_WIDTH      = 32,
  parameter int unsigned MIN_INTERVAL_MS = 30000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire bcsm_cmd_t             cmd_i,
  output bcsm_sts_t                  sts_o,
  bcsm_in_if.sink                    in_if,
  bcsm_out_if.source                 out_if
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned CMP_W = (TW > 32) ? TW : 32;

  // Configuration
  logic [6:0]  low_thr_q;
  logic        alerts_on_q, low_alert_on_q, chg_alert_on_q, full_alert_on_q;
  logic [31:0] full_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q       <= '0;
      alerts_on_q     <= 1'b1;
      low_alert_on_q  <= 1'b1;
      chg_alert_on_q  <= 1'b1;
      full_alert_on_q <= 1'b1;
      full_hold_q     <= 32'd600000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_THR:    low_thr_q       <= cfg_data_i[6:0];
        REG_ALERTS_ON:  alerts_on_q     <= cfg_data_i[0];
        REG_LOW_ALERT:  low_alert_on_q  <= cfg_data_i[0];
        REG_CHG_ALERT:  chg_alert_on_q  <= cfg_data_i[0];
        REG_FULL_ALERT: full_alert_on_q <= cfg_data_i[0];
        REG_FULL_HOLD:  full_hold_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured sample
  logic [11:0]   volt_q;
  logic [14:0]   pct_q;
  logic [TW-1:0] now_q;
  logic [14:0]   pct_clamped;

  assign pct_clamped = (in_if.soc_raw > 16'(PCT_FULL_Q8)) ? PCT_FULL_Q8 : in_if.soc_raw[14:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      volt_q <= in_if.vcell_raw[15:4];
      pct_q  <= pct_clamped;
      now_q  <= TW'(in_if.now_ms);
    end
  end

  // Persistent state
  logic               primed_q;
  logic [14:0]        ref_pct_q;
  logic [TW-1:0]      ref_time_q;
  logic signed [24:0] smooth_q;
  logic               full_pend_q;
  logic [TW-1:0]      full_since_q;
  logic               prev_low_q, prev_chg_q, prev_full_q;

  // Elapsed time since the rate reference
  logic [TW-1:0] dt;
  assign dt = now_q - ref_time_q;

  // Rate arithmetic
  logic signed [15:0]     dq;
  logic signed [39:0]     prod_q;
  logic signed [39:0]     raw;
  logic signed [39:0]     sum_q;
  logic signed [39:0]     sum_d;
  logic signed [39:0]     mixed;
  logic [RATE_DIV_W-1:0]  prod_mag, quo;
  logic [31:0]            sum_mag;
  logic [63:0]            mix_prod;
  logic [28:0]            quo10;
  logic                   div_done;

  assign dq       = $signed({1'b0, pct_q}) - $signed({1'b0, ref_pct_q});
  assign prod_mag = prod_q[39] ? RATE_DIV_W'(-prod_q) : prod_q[RATE_DIV_W-1:0];
  assign raw      = prod_q[39] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum_d    = 40'sd7 * 40'(smooth_q) + 40'sd3 * raw;

  // Divide the weighted sum by ten with a reciprocal multiply, truncating toward zero
  assign sum_mag  = sum_q[39] ? 32'(-sum_q) : sum_q[31:0];
  assign mix_prod = {32'd0, sum_mag} * {32'd0, RECIP10};
  assign quo10    = mix_prod[63:35];
  assign mixed    = sum_q[39] ? -$signed({11'd0, quo10}) : $signed({11'd0, quo10});

  bcsm_div #(
    .NUM_W (RATE_DIV_W),
    .DEN_W (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_mag),
    .den_i   (dt),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // Register the product and the weighted sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 40'(dq) * RATE_SCALE;
    end
    if (cmd_i.mix) begin
      sum_q <= sum_d;
    end
  end

  // Flags of the current sample
  logic          charging, low, cand, full, crit;
  logic [6:0]    thr;
  logic [TW-1:0] since, held;
  logic [1:0]    cstate, chg_alert;
  logic          low_alert, full_alert;

  always_comb begin
    thr      = (low_thr_q != 7'd0) ? low_thr_q : LOW_THR_DEF;
    charging = (smooth_q > RATE_THRESH) && (pct_q < PCT_99_Q8);
    low      = pct_q < {thr, 8'd0};
    cand     = (pct_q >= PCT_99_Q8) && (volt_q >= FULL_VOLT) && (smooth_q < RATE_THRESH);
    since    = full_pend_q ? full_since_q : now_q;
    held     = now_q - since;
    full     = cand && (CMP_W'(held) >= CMP_W'(full_hold_q));
    if (pct_q < PCT_10_Q8) begin
      cstate = CS_CRITICAL;
    end else if (full) begin
      cstate = CS_FULL;
    end else if (charging) begin
      cstate = CS_CHARGING;
    end else begin
      cstate = CS_DISCHARGING;
    end
    low_alert  = alerts_on_q && low_alert_on_q && low && !prev_low_q;
    full_alert = alerts_on_q && full_alert_on_q && full && !prev_full_q;
    crit       = alerts_on_q && (pct_q < PCT_5_Q8);
    chg_alert  = CA_NONE;
    if (alerts_on_q && chg_alert_on_q) begin
      if (charging && !prev_chg_q) begin
        chg_alert = CA_STARTED;
      end else if (!charging && prev_chg_q) begin
        chg_alert = CA_STOPPED;
      end
    end
  end

  // Update state on prime, rate and commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      ref_pct_q    <= '0;
      ref_time_q   <= '0;
      smooth_q     <= '0;
      full_pend_q  <= 1'b0;
      full_since_q <= '0;
      prev_low_q   <= 1'b0;
      prev_chg_q   <= 1'b0;
      prev_full_q  <= 1'b0;
    end else begin
      if (cmd_i.prime) begin
        primed_q   <= 1'b1;
        ref_pct_q  <= pct_q;
        ref_time_q <= now_q;
        smooth_q   <= '0;
      end
      if (cmd_i.rate) begin
        ref_pct_q  <= pct_q;
        ref_time_q <= now_q;
        if (mixed > RATE_MAX) begin
          smooth_q <= RATE_MAX[24:0];
        end else if (mixed < RATE_MIN) begin
          smooth_q <= RATE_MIN[24:0];
        end else begin
          smooth_q <= mixed[24:0];
        end
      end
      if (cmd_i.commit) begin
        full_pend_q <= cand;
        if (cand && !full_pend_q) begin
          full_since_q <= now_q;
        end
        prev_low_q  <= low;
        prev_chg_q  <= charging;
        prev_full_q <= full;
      end
    end
  end

  // Output word
  logic        out_valid_q;
  logic [11:0] o_volt_q;
  logic [14:0] o_pct_q;
  logic [24:0] o_rate_q;
  logic        o_chg_q, o_full_q, o_low_q, o_lowa_q, o_fulla_q, o_crit_q;
  logic [1:0]  o_cs_q, o_chga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      o_volt_q  <= volt_q;
      o_pct_q   <= pct_q;
      o_rate_q  <= smooth_q;
      o_chg_q   <= charging;
      o_full_q  <= full;
      o_low_q   <= low;
      o_cs_q    <= cstate;
      o_lowa_q  <= low_alert;
      o_chga_q  <= chg_alert;
      o_fulla_q <= full_alert;
      o_crit_q  <= crit;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.voltage_units  = o_volt_q;
  assign out_if.percent_q8     = o_pct_q;
  assign out_if.rate_q         = o_rate_q;
  assign out_if.charging       = o_chg_q;
  assign out_if.full_res       = o_full_q;
  assign out_if.low            = o_low_q;
  assign out_if.charge_state   = o_cs_q;
  assign out_if.low_alert      = o_lowa_q;
  assign out_if.charge_alert   = o_chga_q;
  assign out_if.full_alert     = o_fulla_q;
  assign out_if.critical_sleep = o_crit_q;

  // Status to the controller
  assign sts_o.need_rate = primed_q && (CMP_W'(dt) >= CMP_W'(MIN_INTERVAL_MS));
  assign sts_o.primed    = primed_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_if.ready;

endmodule

`default_nettype wire

FILE: hw/rtl/bcsm_ctrl.sv
// ----------------------------------------------------------------------------
// bcsm_ctrl
// Sequencer for sample capture, the interval division, the mix and result commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcsm_ctrl
  import bcsm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire bcsm_sts_t sts_i,
  output bcsm_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_START1 = 6'b000100,
    S_DIV1   = 6'b001000,
    S_RATE   = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.primed) begin
          cmd_o.prime = 1'b1;
          state_d     = S_FIN;
        end else if (sts_i.need_rate) begin
          cmd_o.mul = 1'b1;
          state_d   = S_START1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_START1: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV1;
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.mix = 1'b1;
          state_d   = S_RATE;
        end
      end
      S_RATE: begin
        cmd_o.rate = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BCSM_ASSERT(a_commit_free, cmd_o.commit |-> sts_i.out_free)
  `BCSM_ASSERT_NEXT(a_start_clears_done, cmd_o.div_start, !sts_i.div_done)
  `BCSM_ASSERT(a_mix_after_div, cmd_o.mix |-> sts_i.div_done)

endmodule

`default_nettype wire

FILE: hw/rtl/battery_charge_state_monitor_top.sv
// ----------------------------------------------------------------------------
// battery_charge_state_monitor_top
// Fuel-gauge sample monitor: rate, flags, charge state and alerts.
// ----------------------------------------------------------------------------
// Flow: accept, check, then commit when no rate update is due; with a rate update,
// multiply, the 39-step serial divider for the time interval, mix and rate come first.
// Throughput: one word in flight; the next word is accepted in the idle state that
// follows the commit that registers the result. Output stalls hold the commit.
// Reset: asynchronous active low, clears state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_state_monitor_top
  import bcsm_pkg::*;
#(
  parameter int unsigned TIME_WIDTH      = 32,
  parameter int unsigned MIN_INTERVAL_MS = 30000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bcsm_in_if.sink                    in_if,
  bcsm_out_if.source                 out_if
);

  bcsm_cmd_t cmd;
  bcsm_sts_t sts;

  bcsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcsm_datapath #(
    .TIME_WIDTH      (TIME_WIDTH),
    .MIN_INTERVAL_MS (MIN_INTERVAL_MS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_if      (in_if),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

FILE: sim/bcsm_checker.sv
// ----------------------------------------------------------------------------
// bcsm_checker
// Status predictor and scoreboard for the charge-state monitor.
// ----------------------------------------------------------------------------
// Watches the sample and status channels and the register write port. It keeps
// its own copy of the monitor state, predicts one status word per accepted
// sample and compares every field of each status word against the oldest
// prediction.
`timescale 1ns / 1ps
`default_nettype none

module bcsm_checker
  import bcsm_pkg::*;
#(
  parameter int unsigned MIN_INTERVAL_MS = 30000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bcsm_in_if                         in_mon,
  bcsm_out_if                        out_mon,
  output int                         errors_o,
  output int                         pending_o,
  output int                         seen_o
);

  typedef struct packed {
    logic [11:0]        volt;
    logic [14:0]        pct;
    logic signed [24:0] rate;
    logic               charging;
    logic               full;
    logic               low;
    logic [1:0]         state;
    logic               low_alert;
    logic [1:0]         charge_alert;
    logic               full_alert;
    logic               crit;
  } status_t;

  status_t status_q[$];

  // Register copy
  logic [6:0]  thr_pct;
  logic        alerts_en, low_en, chg_en, full_en;
  logic [31:0] hold_ms;

  // Monitor state copy
  logic        primed;
  logic [14:0] ref_pct;
  logic [31:0] ref_t;
  longint      smooth;
  logic        full_pend;
  logic [31:0] full_t0;
  logic        was_low, was_charging, was_full;

  assign pending_o = status_q.size();

  // Predict the status word for one sample and advance the state
  function automatic status_t predict_status(logic [15:0] vraw, logic [15:0] sraw,
                                             logic [31:0] now);
    status_t     s;
    logic [31:0] dt;
    longint      dq, raw, mix;
    logic [7:0]  thr;
    logic        cand;
    s = '0;
    s.volt = vraw[15:4];
    s.pct  = (sraw > 16'(PCT_FULL_Q8)) ? PCT_FULL_Q8 : sraw[14:0];
    if (!primed) begin
      primed  = 1'b1;
      ref_pct = s.pct;
      ref_t   = now;
      smooth  = 0;
    end else begin
      dt = now - ref_t;
      if (dt >= MIN_INTERVAL_MS) begin
        dq  = longint'(s.pct) - longint'(ref_pct);
        raw = (dq * 64'sd18000000) / longint'({32'd0, dt});
        mix = (7 * smooth + 3 * raw) / 10;
        if (mix > 16777215) mix = 16777215;
        if (mix < -16777216) mix = -16777216;
        smooth  = mix;
        ref_pct = s.pct;
        ref_t   = now;
      end
    end
    s.rate     = smooth[24:0];
    s.charging = (smooth > 256) && (s.pct < PCT_99_Q8);
    thr        = (thr_pct != 0) ? {1'b0, thr_pct} : {1'b0, LOW_THR_DEF};
    s.low      = 32'(s.pct) < 32'(thr) * 256;
    cand       = (s.pct >= PCT_99_Q8) && (s.volt >= FULL_VOLT) && (smooth < 256);
    if (cand) begin
      if (!full_pend) begin
        full_pend = 1'b1;
        full_t0   = now;
      end
    end else begin
      full_pend = 1'b0;
    end
    s.full = cand && ((now - full_t0) >= hold_ms);
    if (s.pct < PCT_10_Q8) s.state = CS_CRITICAL;
    else if (s.full)       s.state = CS_FULL;
    else if (s.charging)   s.state = CS_CHARGING;
    else                   s.state = CS_DISCHARGING;
    s.charge_alert = CA_NONE;
    if (alerts_en) begin
      s.low_alert = s.low && !was_low && low_en;
      if (chg_en) begin
        if (s.charging && !was_charging)      s.charge_alert = CA_STARTED;
        else if (!s.charging && was_charging) s.charge_alert = CA_STOPPED;
      end
      s.full_alert = full_en && s.full && !was_full;
      s.crit       = s.pct < PCT_5_Q8;
    end
    was_low      = s.low;
    was_charging = s.charging;
    was_full     = s.full;
    return s;
  endfunction

  // Track registers, predict on accepted samples, compare accepted status words
  always @(posedge clk_i or negedge rst_ni) begin
    status_t exp_s, got;
    if (!rst_ni) begin
      thr_pct = '0; alerts_en = 1'b1; low_en = 1'b1; chg_en = 1'b1; full_en = 1'b1;
      hold_ms = 32'd600000;
      primed = 1'b0; ref_pct = '0; ref_t = '0; smooth = 0; full_pend = 1'b0;
      full_t0 = '0; was_low = 1'b0; was_charging = 1'b0; was_full = 1'b0;
      errors_o <= 0;
      seen_o   <= 0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW_THR:    thr_pct   = cfg_data_i[6:0];
          REG_ALERTS_ON:  alerts_en = cfg_data_i[0];
          REG_LOW_ALERT:  low_en    = cfg_data_i[0];
          REG_CHG_ALERT:  chg_en    = cfg_data_i[0];
          REG_FULL_ALERT: full_en   = cfg_data_i[0];
          REG_FULL_HOLD:  hold_ms   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        status_q.push_back(predict_status(in_mon.vcell_raw, in_mon.soc_raw, in_mon.now_ms));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.voltage_units, out_mon.percent_q8, out_mon.rate_q, out_mon.charging,
               out_mon.full_res, out_mon.low, out_mon.charge_state, out_mon.low_alert,
               out_mon.charge_alert, out_mon.full_alert, out_mon.critical_sleep};
        seen_o <= seen_o + 1;
        if (status_q.size() == 0) begin
          $display("%0t: status word with no sample pending: %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_s = status_q.pop_front();
          if (got !== exp_s) begin
            $display("%0t: status mismatch", $time);
            $display("  expected %p", exp_s);
            $display("  actual   %p", got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/battery_charge_state_monitor_top_tb.sv
// ----------------------------------------------------------------------------
// battery_charge_state_monitor_top_tb
// Stimulus and verdict for the charge-state monitor.
// ----------------------------------------------------------------------------
// Runs directed corner samples, then several register settings each followed
// by random sample streams (mostly plausible charge walks, some noise) with
// random gaps on both channels. The checker does all comparison.
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_state_monitor_top_tb;
  import bcsm_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    errors, pending, seen;
  int                    n_words, n_settings;
  logic [31:0]           cur_t;
  int                    cur_soc;
  bit                    burst;

  bcsm_in_if  in_if ();
  bcsm_out_if out_if ();

  battery_charge_state_monitor_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_if, .out_if
  );

  bcsm_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(in_if), .out_mon(out_if),
    .errors_o(errors), .pending_o(pending), .seen_o(seen)
  );

  // Clock, 4 ns period
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Stall the status channel at random, now and then in long stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 499) == 0) begin
      out_if.ready <= 1'b0;
      repeat ($urandom_range(20, 60)) @(posedge clk_i);
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_if.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // Send one sample word and hold it until accepted
  task automatic send_word(logic [15:0] v, logic [15:0] s, logic [31:0] t);
    int gap;
    gap = burst ? 0 : (($urandom_range(0, 14) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2));
    if ($urandom_range(0, 39) == 0) burst = !burst;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.vcell_raw <= v;
    in_if.soc_raw   <= s;
    in_if.now_ms    <= t;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    n_words++;
  endtask

  // Drop valid and wait until every status word is back, then settle
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
  endtask

  // Write one register; caller lowers the enable after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_regs(int thr, bit al, bit la, bit ca, bit fa, logic [31:0] hold);
    write_reg(REG_LOW_THR, CFG_DATA_W'(thr));
    write_reg(REG_ALERTS_ON, CFG_DATA_W'(al));
    write_reg(REG_LOW_ALERT, CFG_DATA_W'(la));
    write_reg(REG_CHG_ALERT, CFG_DATA_W'(ca));
    write_reg(REG_FULL_ALERT, CFG_DATA_W'(fa));
    write_reg(REG_FULL_HOLD, hold);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // Random stream: mostly a charge walk with plausible timing, some noise
  task automatic random_stream(int count);
    logic [15:0] v;
    int          mode;
    repeat (count) begin
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
        v     = 16'($urandom);
        cur_t = $urandom;
        send_word(v, 16'($urandom), cur_t);
      end else begin
        if (mode < 15)      cur_soc = $urandom_range(0, 3000);
        else if (mode < 25) cur_soc = $urandom_range(25200, 26000);
        else cur_soc += $urandom_range(0, 1200) - 500;
        if (cur_soc < 0) cur_soc = 0;
        if (cur_soc > 27000) cur_soc = 27000;
        cur_t += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 29999)
                                             : $urandom_range(30000, 90000);
        if ($urandom_range(0, 49) == 0) cur_t += $urandom_range(600000, 1200000);
        v = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(53120, 65535))
                                        : 16'($urandom_range(40000, 53200));
        send_word(v, 16'(cur_soc), cur_t);
      end
    end
  endtask

  // Fail and end the run on timeout
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.vcell_raw = '0;
    in_if.soc_raw   = '0;
    in_if.now_ms    = '0;
    n_words = 0; n_settings = 0; burst = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first sample, clamps, thresholds, short interval, time wrap
    set_regs(0, 1, 1, 1, 1, 0);
    send_word(16'hFFFF, 16'hFFFF, 32'hFFFF_F000);
    send_word(16'd53120, 16'd25600, 32'h0000_0100);
    send_word(16'd53119, 16'd25344, 32'h0000_7630);
    send_word(16'd53120, 16'd25343, 32'h0000_EC80);
    send_word(16'd0, 16'd0, 32'h0001_62D0);
    send_word(16'd0, 16'd1279, 32'h0001_62D1);
    send_word(16'd0, 16'd1280, 32'h0001_D8F1);
    send_word(16'd100, 16'd2559, 32'h0002_4F21);
    send_word(16'd100, 16'd2560, 32'h0002_C551);
    send_word(16'd100, 16'd25600, 32'h0003_3B81);
    send_word(16'd100, 16'd25600, 32'h0003_B1B1);
    send_word(16'd65535, 16'd25600, 32'hFFFF_FFFF);
    send_word(16'd65535, 16'd25600, 32'h0000_7530);
    send_word(16'd65535, 16'd32768, 32'h8000_0000);
    send_word(16'd65535, 16'd3839, 32'h0000_0000);
    send_word(16'd65535, 16'd3840, 32'h0000_7530);
    drain();

    // Random phases across register extremes
    set_regs(0, 1, 1, 1, 1, 0);
    cur_t = 32'hFFF0_0000; cur_soc = 12000;
    random_stream(270);
    drain();
    set_regs(100, 1, 1, 0, 1, 1000);
    random_stream(270);
    drain();
    set_regs(127, 0, 1, 1, 1, 30000);
    random_stream(270);
    drain();
    set_regs(1, 1, 0, 1, 0, 600000);
    random_stream(270);
    drain();
    set_regs(50, 1, 1, 1, 1, 32'hFFFF_FFFF);
    random_stream(270);
    drain();
    set_regs(20, 1, 1, 1, 1, 120000);
    random_stream(270);
    drain();

    $display("Sent %0d sample words under %0d register settings, %0d status words checked",
             n_words, n_settings, seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
